@@ rtl/wsd_pkg.sv @@
// Shared types, codes and helpers for the WebSocket frame deframer.
package wsd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_PAY  = 3'd4
    } wsd_phase_t;

    localparam logic [1:0] EV_PAYLOAD   = 2'd0;
    localparam logic [1:0] EV_EMPTY     = 2'd1;
    localparam logic [1:0] EV_HEARTBEAT = 2'd2;
    localparam logic [1:0] EV_CLOSE     = 2'd3;

    localparam logic [2:0] KIND_CONT     = 3'd0;
    localparam logic [2:0] KIND_TEXT     = 3'd1;
    localparam logic [2:0] KIND_BINARY   = 3'd2;
    localparam logic [2:0] KIND_CLOSE    = 3'd3;
    localparam logic [2:0] KIND_PING     = 3'd4;
    localparam logic [2:0] KIND_PONG     = 3'd5;
    localparam logic [2:0] KIND_RESERVED = 3'd6;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [6:0] LEN_EXT16 = 7'h7E;
    localparam logic [6:0] LEN_EXT64 = 7'h7F;

    localparam int LEN_W = 63;

    typedef struct packed {
        logic [1:0]       event_res;
        logic [7:0]       data_raw;
        logic [7:0]       key_byte;
        logic [2:0]       frame_kind;
        logic             final_fragment;
        logic             last_of_frame;
        logic [LEN_W-1:0] frame_length;
    } wsd_item_t;

    function automatic logic [2:0] map_opcode(input logic [3:0] op);
        logic [2:0] k;
        case (op)
            OP_CONT:   k = KIND_CONT;
            OP_TEXT:   k = KIND_TEXT;
            OP_BINARY: k = KIND_BINARY;
            OP_CLOSE:  k = KIND_CLOSE;
            OP_PING:   k = KIND_PING;
            OP_PONG:   k = KIND_PONG;
            default:   k = KIND_RESERVED;
        endcase
        return k;
    endfunction

endpackage

@@ rtl/wsd_front.sv @@
// Header parser that classifies each received byte and queues result items.
module wsd_front
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] stream_byte,
    output logic       push,
    output wsd_item_t  item
);

    wsd_phase_t       phase_reg, phase_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic             fin_reg, fin_next;
    logic [2:0]       kind_reg, kind_next;
    logic             masked_reg, masked_next;
    logic [LEN_W-1:0] length_reg, length_next;
    logic [31:0]      key_reg, key_next;
    logic [LEN_W-1:0] left_reg, left_next;
    logic [1:0]       idx_reg, idx_next;

    logic             after_len;
    logic             finish;
    logic             is_ctrl;
    logic [3:0]       cnt_dec;
    logic [LEN_W-1:0] left_dec;
    logic [7:0]       key_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            cnt_reg    <= '0;
            fin_reg    <= 1'b0;
            kind_reg   <= KIND_CONT;
            masked_reg <= 1'b0;
            length_reg <= '0;
            key_reg    <= '0;
            left_reg   <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            fin_reg    <= fin_next;
            kind_reg   <= kind_next;
            masked_reg <= masked_next;
            length_reg <= length_next;
            key_reg    <= key_next;
            left_reg   <= left_next;
            idx_reg    <= idx_next;
        end
    end

    always_comb
    begin
        case (idx_reg)
            2'd0:    key_sel = key_reg[31:24];
            2'd1:    key_sel = key_reg[23:16];
            2'd2:    key_sel = key_reg[15:8];
            default: key_sel = key_reg[7:0];
        endcase
    end

    assign is_ctrl  = (kind_reg inside {KIND_CLOSE, KIND_PING, KIND_PONG});
    assign cnt_dec  = cnt_reg - 4'd1;
    assign left_dec = (left_reg != '0) ? left_reg - {{(LEN_W-1){1'b0}}, 1'b1} : '0;

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        fin_next    = fin_reg;
        kind_next   = kind_reg;
        masked_next = masked_reg;
        length_next = length_reg;
        key_next    = key_reg;
        left_next   = left_reg;
        idx_next    = idx_reg;
        after_len   = 1'b0;
        finish      = 1'b0;
        push        = 1'b0;
        item.event_res      = EV_PAYLOAD;
        item.data_raw       = 8'd0;
        item.key_byte       = 8'd0;
        item.frame_kind     = kind_reg;
        item.final_fragment = fin_reg;
        item.last_of_frame  = 1'b0;
        item.frame_length   = length_reg;

        if (take)
        begin
            case (phase_reg)
                PH_HDR1:
                begin
                    masked_next = stream_byte[7];
                    if (stream_byte[6:0] == LEN_EXT16 || stream_byte[6:0] == LEN_EXT64)
                    begin
                        length_next = '0;
                        cnt_next    = (stream_byte[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
                        phase_next  = PH_EXT;
                    end
                    else
                    begin
                        length_next = {{(LEN_W-7){1'b0}}, stream_byte[6:0]};
                        after_len   = 1'b1;
                    end
                end
                PH_EXT:
                begin
                    length_next = {length_reg[LEN_W-9:0], stream_byte};
                    cnt_next    = cnt_dec;
                    after_len   = (cnt_dec == 4'd0);
                end
                PH_MASK:
                begin
                    key_next = {key_reg[23:0], stream_byte};
                    cnt_next = cnt_dec;
                    finish   = (cnt_dec == 4'd0);
                end
                PH_PAY:
                begin
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        phase_next = PH_HDR0;
                    end
                    if (!is_ctrl)
                    begin
                        push                = 1'b1;
                        item.event_res      = EV_PAYLOAD;
                        item.data_raw       = stream_byte;
                        item.key_byte       = masked_reg ? key_sel : 8'd0;
                        item.last_of_frame  = (left_dec == '0);
                        idx_next            = idx_reg + 2'd1;
                    end
                end
                default:
                begin
                    fin_next   = stream_byte[7];
                    kind_next  = map_opcode(stream_byte[3:0]);
                    cnt_next   = '0;
                    phase_next = PH_HDR1;
                end
            endcase

            if (after_len)
            begin
                if (masked_next)
                begin
                    key_next   = '0;
                    cnt_next   = 4'd4;
                    phase_next = PH_MASK;
                end
                else
                begin
                    finish = 1'b1;
                end
            end

            if (finish)
            begin
                idx_next          = '0;
                left_next         = length_next;
                item.frame_length = length_next;
                item.last_of_frame = 1'b1;
                if (is_ctrl)
                begin
                    phase_next     = (length_next != '0) ? PH_PAY : PH_HDR0;
                    push           = 1'b1;
                    item.event_res = (kind_reg == KIND_CLOSE) ? EV_CLOSE : EV_HEARTBEAT;
                end
                else if (length_next == '0)
                begin
                    phase_next     = PH_HDR0;
                    push           = 1'b1;
                    item.event_res = EV_EMPTY;
                end
                else
                begin
                    phase_next = PH_PAY;
                end
            end
        end
    end

endmodule

@@ rtl/wsd_fifo.sv @@
// Short queue of result items between the parser and the output stage.
module wsd_fifo
    import wsd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  wsd_item_t push_item,
    output logic      ready,
    output logic      valid,
    input  logic      pop,
    output wsd_item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wsd_item_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign ready     = (count_reg != CNT_W'(DEPTH));
    assign valid     = (count_reg != '0);
    assign do_push   = push && ready;
    assign do_pop    = pop && valid;
    assign head_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/wsd_back.sv @@
// Output stage that unmasks payload bytes and holds the result beat.
module wsd_back
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  wsd_item_t   item,
    output logic        pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,
    output logic [5:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    logic             valid_reg;
    logic [7:0]       data_reg;
    logic [1:0]       event_reg;
    logic [2:0]       kind_reg;
    logic             fin_reg;
    logic             last_reg;
    logic [LEN_W-1:0] length_reg;

    assign pop = item_valid && (!valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg   <= item.data_raw ^ item.key_byte;
            event_reg  <= item.event_res;
            kind_reg   <= item.frame_kind;
            fin_reg    <= item.final_fragment;
            last_reg   <= item.last_of_frame;
            length_reg <= item.frame_length;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {1'b0, length_reg, data_reg};
    assign m_axis_tuser  = {fin_reg, kind_reg, event_reg};
    assign m_axis_tlast  = last_reg;

endmodule

@@ rtl/websocket_frame_deframer.sv @@
// Top level of the WebSocket receive deframer and unmasker.
// Accepts one stream byte per cycle while the result queue is not full; a full queue drops s_axis_tready.
// A result beat reaches the master side through the result queue and then the output register.
// Header bytes that complete no control or empty frame give no beat.
// Reset is asynchronous and active low; parsing restarts at the first header byte.
module websocket_frame_deframer
    import wsd_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [7:0] data_byte, [70:8] frame_length, [71] zero
    output logic [5:0]  m_axis_tuser,   // [1:0] event_res, [4:2] frame_kind, [5] final_fragment
    output logic        m_axis_tlast
);

    logic      take;
    logic      push;
    wsd_item_t push_item;
    logic      q_valid;
    logic      q_pop;
    wsd_item_t head_item;

    assign take = s_axis_tvalid && s_axis_tready;

    wsd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .stream_byte (s_axis_tdata),
        .push        (push),
        .item        (push_item)
    );

    wsd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .ready     (s_axis_tready),
        .valid     (q_valid),
        .pop       (q_pop),
        .head_item (head_item)
    );

    wsd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (q_valid),
        .item          (head_item),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ bench/websocket_frame_deframer_tb.sv @@
// Self-checking bench for the WebSocket deframer: streams frames and noise, predicts result beats.
`timescale 1ns / 1ps

module websocket_frame_deframer_tb
    import wsd_pkg::*;
();

    localparam int CLK_HALF    = 4;
    localparam int RAND_ITEMS  = 680;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 16;
    localparam int REPORT_CAP  = 40;

    localparam int ENC_SHORT = 0;
    localparam int ENC_16    = 1;
    localparam int ENC_64    = 2;

    typedef struct packed {
        logic [1:0]       ev;
        logic [7:0]       data;
        logic [2:0]       kind;
        logic             fin;
        logic             last;
        logic [LEN_W-1:0] len;
    } deframe_res_t;

    typedef struct packed {
        logic [7:0]   b;
        bit           fixed;
        deframe_res_t res;
    } dir_row_t;

    localparam deframe_res_t NO_RES = '0;

    dir_row_t dir_rows [28] = '{
        '{8'h89, 1'b0, NO_RES},
        '{8'h00, 1'b1, '{EV_HEARTBEAT, 8'h00, KIND_PING, 1'b1, 1'b1, 63'd0}},
        '{8'h88, 1'b0, NO_RES},
        '{8'h01, 1'b1, '{EV_CLOSE, 8'h00, KIND_CLOSE, 1'b1, 1'b1, 63'd1}},
        '{8'hA5, 1'b0, NO_RES},
        '{8'h7F, 1'b0, NO_RES},
        '{8'h7F, 1'b0, NO_RES},
        '{8'h80, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES},
        '{8'h00, 1'b1, '{EV_EMPTY, 8'h00, KIND_RESERVED, 1'b0, 1'b1, 63'd0}},
        '{8'h81, 1'b0, NO_RES},
        '{8'hFE, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES},
        '{8'h01, 1'b0, NO_RES},
        '{8'h11, 1'b0, NO_RES},
        '{8'h22, 1'b0, NO_RES},
        '{8'h33, 1'b0, NO_RES},
        '{8'h44, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'h02, 1'b0, NO_RES},
        '{8'h00, 1'b1, '{EV_EMPTY, 8'h00, KIND_BINARY, 1'b0, 1'b1, 63'd0}},
        '{8'h8A, 1'b0, NO_RES},
        '{8'h00, 1'b1, '{EV_HEARTBEAT, 8'h00, KIND_PONG, 1'b1, 1'b1, 63'd0}}
    };

    logic [3:0] known_ops [6] = '{OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [5:0]  m_axis_tuser;
    logic        m_axis_tlast;

    wsd_phase_t  cur_phase = PH_HDR0;
    logic [3:0]  hdr_left = 4'd0;
    logic        cur_fin = 1'b0;
    logic [2:0]  cur_kind = KIND_CONT;
    logic        cur_masked = 1'b0;
    logic [63:0] cur_len = 64'd0;
    logic [31:0] cur_key = 32'd0;
    logic [63:0] pay_left = 64'd0;
    logic [1:0]  key_pos = 2'd0;

    deframe_res_t pending_results [$];
    int mismatch_count = 0;
    int n_bytes = 0;
    int n_frames = 0;
    int n_noise = 0;
    int ev_seen [4] = '{0, 0, 0, 0};
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_asked = 0;
    int hold_done = 0;
    int hold_left = 0;
    int cycle_count = 0;

    websocket_frame_deframer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF clk = ~clk;

    function automatic logic [2:0] kind_of_opcode(input logic [3:0] op);
        case (op)
            OP_CONT:   return KIND_CONT;
            OP_TEXT:   return KIND_TEXT;
            OP_BINARY: return KIND_BINARY;
            OP_CLOSE:  return KIND_CLOSE;
            OP_PING:   return KIND_PING;
            OP_PONG:   return KIND_PONG;
            default:   return KIND_RESERVED;
        endcase
    endfunction

    function automatic bit is_control_kind();
        return cur_kind == KIND_CLOSE || cur_kind == KIND_PING || cur_kind == KIND_PONG;
    endfunction

    function automatic deframe_res_t frame_res(input logic [1:0] ev, input logic [7:0] d,
                                               input logic last);
        deframe_res_t r;
        r.ev   = ev;
        r.data = d;
        r.kind = cur_kind;
        r.fin  = cur_fin;
        r.last = last;
        r.len  = cur_len[LEN_W-1:0];
        return r;
    endfunction

    task automatic close_header(output bit got, output deframe_res_t r);
        key_pos  = 2'd0;
        pay_left = cur_len;
        got      = 1'b1;
        r        = '0;
        if (is_control_kind())
        begin
            cur_phase = (cur_len != 0) ? PH_PAY : PH_HDR0;
            r = frame_res((cur_kind == KIND_CLOSE) ? EV_CLOSE : EV_HEARTBEAT, 8'h00, 1'b1);
        end
        else if (cur_len == 0)
        begin
            cur_phase = PH_HDR0;
            r = frame_res(EV_EMPTY, 8'h00, 1'b1);
        end
        else
        begin
            cur_phase = PH_PAY;
            got = 1'b0;
        end
    endtask

    task automatic end_of_length(output bit got, output deframe_res_t r);
        got = 1'b0;
        r   = '0;
        if (cur_masked)
        begin
            cur_key   = 32'd0;
            hdr_left  = 4'd4;
            cur_phase = PH_MASK;
        end
        else
            close_header(got, r);
    endtask

    task automatic parse_byte(input logic [7:0] b, output bit got, output deframe_res_t r);
        logic       last_b;
        logic [7:0] kb;
        got = 1'b0;
        r   = '0;
        case (cur_phase)
            PH_HDR1:
            begin
                cur_masked = b[7];
                if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64)
                begin
                    cur_len   = 64'd0;
                    hdr_left  = (b[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
                    cur_phase = PH_EXT;
                end
                else
                begin
                    cur_len = {57'd0, b[6:0]};
                    end_of_length(got, r);
                end
            end
            PH_EXT:
            begin
                cur_len  = {cur_len[55:0], b};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left == 0)
                begin
                    cur_len[63] = 1'b0;
                    end_of_length(got, r);
                end
            end
            PH_MASK:
            begin
                cur_key  = {cur_key[23:0], b};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left == 0)
                    close_header(got, r);
            end
            PH_PAY:
            begin
                if (pay_left != 0)
                    pay_left = pay_left - 64'd1;
                last_b = (pay_left == 0);
                if (last_b)
                    cur_phase = PH_HDR0;
                if (!is_control_kind())
                begin
                    kb = cur_masked ? cur_key[8 * (3 - int'(key_pos)) +: 8] : 8'h00;
                    key_pos = key_pos + 2'd1;
                    got = 1'b1;
                    r = frame_res(EV_PAYLOAD, b ^ kb, last_b);
                end
            end
            default:
            begin
                cur_fin   = b[7];
                cur_kind  = kind_of_opcode(b[3:0]);
                hdr_left  = 4'd0;
                cur_phase = PH_HDR1;
            end
        endcase
    endtask

    task automatic accept_byte(input logic [7:0] b, input bit fixed = 1'b0,
                               input deframe_res_t fixed_res = '0);
        bit           got;
        deframe_res_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        n_bytes++;
        parse_byte(b, got, r);
        if (fixed)
            pending_results = {pending_results, fixed_res};
        else if (got)
            pending_results = {pending_results, r};
    endtask

    // Length bytes are held small so that a corrupted header cannot swallow the rest of the run.
    function automatic logic [7:0] sane_byte();
        logic [7:0] v;
        v = 8'($urandom_range(255));
        if (cur_phase == PH_EXT)
        begin
            if (hdr_left > 2)
                v = (hdr_left == 8) ? {v[7], 7'd0} : 8'd0;
            else if (hdr_left == 2)
                v = {7'd0, v[0]};
        end
        return v;
    endfunction

    task automatic send_frame(input logic [7:0] first, input bit mask_on, input int enc,
                              input logic [63:0] len, input int n_pay);
        logic [31:0] k;
        k = $urandom;
        accept_byte(first);
        case (enc)
            ENC_SHORT:
                accept_byte({mask_on, len[6:0]});
            ENC_16:
            begin
                accept_byte({mask_on, LEN_EXT16});
                accept_byte(len[15:8]);
                accept_byte(len[7:0]);
            end
            default:
            begin
                accept_byte({mask_on, LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    accept_byte(len[8 * i +: 8]);
            end
        endcase
        if (mask_on)
            for (int i = 3; i >= 0; i--)
                accept_byte(k[8 * i +: 8]);
        repeat (n_pay)
            accept_byte(8'($urandom_range(255)));
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
        if (mismatch_count < REPORT_CAP)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_asked != hold_done)
        begin
            hold_done <= hold_asked;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        deframe_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                if (mismatch_count < REPORT_CAP)
                    $display("%0t: unexpected result beat, expected none, actual tdata %0h tuser %0h",
                             $time, m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                ev_seen[want.ev]++;
                if (m_axis_tuser[1:0] !== want.ev)
                    flag_mismatch("event_res", 64'(want.ev), 64'(m_axis_tuser[1:0]));
                if (m_axis_tdata[7:0] !== want.data)
                    flag_mismatch("data_byte", 64'(want.data), 64'(m_axis_tdata[7:0]));
                if (m_axis_tuser[4:2] !== want.kind)
                    flag_mismatch("frame_kind", 64'(want.kind), 64'(m_axis_tuser[4:2]));
                if (m_axis_tuser[5] !== want.fin)
                    flag_mismatch("final_fragment", 64'(want.fin), 64'(m_axis_tuser[5]));
                if (m_axis_tlast !== want.last)
                    flag_mismatch("last_of_frame", 64'(want.last), 64'(m_axis_tlast));
                if (m_axis_tdata[70:8] !== want.len)
                    flag_mismatch("frame_length", 64'(want.len), 64'(m_axis_tdata[70:8]));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int          rand_start;
        int          stage;
        int          pick;
        int          enc;
        int          n_pay;
        logic [31:0] rnd;
        logic [7:0]  first;
        logic [63:0] len;
        bit          mask_on;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            accept_byte(dir_rows[i].b, dir_rows[i].fixed, dir_rows[i].res);

        rand_start = n_bytes;
        while (n_bytes - rand_start < RAND_ITEMS)
        begin
            stage = (n_bytes - rand_start) * 4 / RAND_ITEMS;
            case (stage)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            // The sender keeps streaming through this hold-off so the block backs up.
            if (hold_asked == 0 && n_bytes - rand_start >= 80)
                hold_asked = 1;

            if ($urandom_range(99) < 10)
            begin
                n_noise++;
                repeat ($urandom_range(6, 1))
                    accept_byte(sane_byte());
            end
            else
            begin
                n_frames++;
                rnd = $urandom;
                first = rnd[7:0];
                if ($urandom_range(99) < 60)
                    first[3:0] = known_ops[$urandom_range(5)];
                mask_on = rnd[8];
                pick = $urandom_range(99);
                if (pick < 85)
                begin
                    enc = ENC_SHORT;
                    pick = $urandom_range(99);
                    if (pick < 20)
                        len = 64'd0;
                    else if (pick < 90)
                        len = 64'($urandom_range(12, 1));
                    else
                        len = 64'($urandom_range(125, 13));
                end
                else if (pick < 94)
                begin
                    enc = ENC_16;
                    if (rnd[9])
                        len = 64'($urandom_range(125));
                    else
                        len = 64'($urandom_range(300, 126));
                end
                else
                begin
                    enc = ENC_64;
                    len = 64'($urandom_range(200));
                    len[63] = rnd[10];
                end
                n_pay = int'(len[31:0]);
                if ($urandom_range(99) < 5)
                    n_pay = $urandom_range(n_pay);
                send_frame(first, mask_on, enc, len, n_pay);
            end
            while (cur_phase != PH_HDR0)
                accept_byte(sane_byte());
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_frame({1'b1, 3'b000, OP_BINARY}, 1'b0, ENC_64, 64'hFFFF_FFFF_FFFF_FFFF, 16);
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Streamed %0d bytes: %0d random frames, %0d noise bursts, with idle, stall",
                 n_bytes, n_frames, n_noise);
        $display("and hold-off phases; beats seen: %0d payload, %0d empty, %0d heartbeat, %0d close.",
                 ev_seen[0], ev_seen[1], ev_seen[2], ev_seen[3]);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ websocket_frame_deframer.f @@
rtl/wsd_pkg.sv
rtl/wsd_front.sv
rtl/wsd_fifo.sv
rtl/wsd_back.sv
rtl/websocket_frame_deframer.sv
bench/websocket_frame_deframer_tb.sv
